>>> sv/sm83alu_pkg.sv
// shared types and operation codes for the sm83 alu block
// no dependencies; used by sm83alu_core and sm83_alu_with_flags

package sm83alu_pkg;

   localparam logic [4:0] OP_ADD   = 5'd0;
   localparam logic [4:0] OP_ADC   = 5'd1;
   localparam logic [4:0] OP_SUB   = 5'd2;
   localparam logic [4:0] OP_SBC   = 5'd3;
   localparam logic [4:0] OP_AND   = 5'd4;
   localparam logic [4:0] OP_XOR   = 5'd5;
   localparam logic [4:0] OP_OR    = 5'd6;
   localparam logic [4:0] OP_CP    = 5'd7;
   localparam logic [4:0] OP_INC   = 5'd8;
   localparam logic [4:0] OP_DEC   = 5'd9;
   localparam logic [4:0] OP_RLC   = 5'd10;
   localparam logic [4:0] OP_RRC   = 5'd11;
   localparam logic [4:0] OP_RL    = 5'd12;
   localparam logic [4:0] OP_RR    = 5'd13;
   localparam logic [4:0] OP_SLA   = 5'd14;
   localparam logic [4:0] OP_SRA   = 5'd15;
   localparam logic [4:0] OP_SRL   = 5'd16;
   localparam logic [4:0] OP_SWAP  = 5'd17;
   localparam logic [4:0] OP_BIT   = 5'd18;
   localparam logic [4:0] OP_RES   = 5'd19;
   localparam logic [4:0] OP_SET   = 5'd20;
   localparam logic [4:0] OP_DAA   = 5'd21;
   localparam logic [4:0] OP_CPL   = 5'd22;
   localparam logic [4:0] OP_SCF   = 5'd23;
   localparam logic [4:0] OP_CCF   = 5'd24;
   localparam logic [4:0] OP_ADD16 = 5'd25;
   localparam logic [4:0] OP_ADDSP = 5'd26;

   localparam logic [7:0] DAA_HI_ADJ  = 8'h60;
   localparam logic [7:0] DAA_LO_ADJ  = 8'h06;
   localparam logic [7:0] DAA_HI_LIM  = 8'h99;
   localparam logic [3:0] DAA_LO_LIM  = 4'h9;

   typedef struct packed {
      logic [4:0]  operation;
      logic [15:0] operand_a;
      logic [15:0] operand_b;
      logic [2:0]  bit_index;
      logic        carry_in;
      logic        half_in;
      logic        subtract_in;
      logic        zero_in;
   } req_type;

   typedef struct packed {
      logic [15:0] result_value;
      logic        write_back;
      logic        carry_out;
      logic        half_out;
      logic        subtract_out;
      logic        zero_out;
   } rsp_type;

endpackage

>>> sv/sm83_alu_with_flags.sv
// top level: input register, sm83alu_core datapath, result register
// depends on sm83alu_pkg and sm83alu_core

// sm83-style 8-bit alu with flag update. each req beat carries an operation
// code, two 16-bit operands, a bit index and the current c/h/n/z flags; each
// produces exactly one rsp beat with the result, a write-back enable (low for
// cp, bit and unused codes) and the new flags. eight-bit operations use the
// low operand bytes and return a zero upper byte; add16 and addsp return a
// full 16-bit value. the block is a two-register pipeline: a beat is captured
// in the input register, goes through one pass of combinational alu logic and
// lands in the result register, which drives rsp_valid and the rsp beat;
// throughput is one beat per cycle while rsp_ready keeps the result moving.
// the single alu pass is the only stage of work, and rsp_ready feeds back to
// req_ready within the same cycle so a stalled result holds both stages
// without losing a beat.
// there is no state beyond the pipeline; reset only clears the valid bits.

module sm83_alu_with_flags (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  sm83alu_pkg::req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output sm83alu_pkg::rsp_type rsp_data
);

   // input stage
   logic                 s1_valid_ff;
   logic                 s1_valid_in;
   sm83alu_pkg::req_type s1_data_ff;

   // result stage
   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   sm83alu_pkg::rsp_type rsp_data_ff;

   sm83alu_pkg::rsp_type core_result;
   logic                 rsp_take;
   logic                 req_take;

   // result register may load when empty or when its beat leaves this cycle
   assign rsp_take  = !rsp_valid_ff || rsp_ready;
   // input register may load when empty or when it moves forward
   assign req_ready = !s1_valid_ff || rsp_take;
   assign req_take  = req_valid && req_ready;

   sm83alu_core u_core (
      .item   (s1_data_ff),
      .result (core_result)
   );

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_take) begin
         s1_valid_in = 1'b1;
      end else if (rsp_take) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_take ? s1_valid_ff : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_data_ff <= req_data;
      end
      if (rsp_take && s1_valid_ff) begin
         rsp_data_ff <= core_result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // an accepted beat always occupies the input stage next cycle
   a_req_lands: assert property (@(posedge clock) disable iff (reset)
      req_take |=> s1_valid_ff)
      else $error("accepted beat missing from input stage");

   // a stalled output must hold the waiting input beat
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && rsp_valid_ff && !rsp_ready) |=> s1_valid_ff)
      else $error("input beat dropped during output stall");

   // compare and bit test never write back
   a_no_wb: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && rsp_take &&
       ((s1_data_ff.operation == sm83alu_pkg::OP_CP) ||
        (s1_data_ff.operation == sm83alu_pkg::OP_BIT)))
      |=> !rsp_data_ff.write_back)
      else $error("write-back set for cp or bit");

   // byte-wide operations leave the upper result byte clear
   a_upper_zero: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && rsp_take &&
       (s1_data_ff.operation < sm83alu_pkg::OP_ADD16))
      |=> (rsp_data_ff.result_value[15:8] == 8'h00))
      else $error("upper byte set on 8-bit operation");

endmodule

>>> sv/sm83alu_core.sv
// combinational datapath: one alu operation with flag update
// depends on sm83alu_pkg

module sm83alu_core (
   input  sm83alu_pkg::req_type item,
   output sm83alu_pkg::rsp_type result
);

   logic [7:0]  a;
   logic [7:0]  b;
   logic        cuse;
   logic [8:0]  add9;
   logic [4:0]  addh5;
   logic [8:0]  sub9;
   logic [4:0]  subh5;
   logic [7:0]  mask;
   logic [16:0] sum17;
   logic [12:0] sum13;
   logic [8:0]  sp9;
   logic [4:0]  sph5;
   logic [15:0] sp16;
   logic [7:0]  daa_r;
   logic        daa_c;
   logic [7:0]  r8;
   logic        c;
   logic        h;
   logic        n;
   logic        z;
   logic        wb;
   logic        wide;
   logic [15:0] r16;

   assign a    = item.operand_a[7:0];
   assign b    = item.operand_b[7:0];
   assign cuse = ((item.operation == sm83alu_pkg::OP_ADC) ||
                  (item.operation == sm83alu_pkg::OP_SBC)) ? item.carry_in : 1'b0;

   // shared adder and subtractor for the 8-bit arithmetic group
   assign add9  = {1'b0, a} + {1'b0, b} + {8'h00, cuse};
   assign addh5 = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'h0, cuse};
   assign sub9  = {1'b0, a} - {1'b0, b} - {8'h00, cuse};
   assign subh5 = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'h0, cuse};

   assign mask = 8'h01 << item.bit_index;

   assign sum17 = {1'b0, item.operand_a} + {1'b0, item.operand_b};
   assign sum13 = {1'b0, item.operand_a[11:0]} + {1'b0, item.operand_b[11:0]};

   // sp plus signed offset, flags from the unsigned low byte
   assign sp9  = {1'b0, item.operand_a[7:0]} + {1'b0, b};
   assign sph5 = {1'b0, item.operand_a[3:0]} + {1'b0, b[3:0]};
   assign sp16 = item.operand_a + {{8{b[7]}}, b};

   // decimal adjust, both tests on the original accumulator
   always_comb begin
      daa_r = a;
      daa_c = item.carry_in;
      if (!item.subtract_in) begin
         if (item.carry_in || (a > sm83alu_pkg::DAA_HI_LIM)) begin
            daa_r = daa_r + sm83alu_pkg::DAA_HI_ADJ;
            daa_c = 1'b1;
         end
         if (item.half_in || (a[3:0] > sm83alu_pkg::DAA_LO_LIM)) begin
            daa_r = daa_r + sm83alu_pkg::DAA_LO_ADJ;
         end
      end else begin
         if (item.carry_in) begin
            daa_r = daa_r - sm83alu_pkg::DAA_HI_ADJ;
         end
         if (item.half_in) begin
            daa_r = daa_r - sm83alu_pkg::DAA_LO_ADJ;
         end
      end
   end

   always_comb begin
      r8   = a;
      r16  = item.operand_a;
      wide = 1'b0;
      wb   = 1'b1;
      c    = item.carry_in;
      h    = item.half_in;
      n    = item.subtract_in;
      z    = item.zero_in;
      case (item.operation)
         sm83alu_pkg::OP_ADD, sm83alu_pkg::OP_ADC: begin
            r8 = add9[7:0];
            c  = add9[8];
            h  = addh5[4];
            n  = 1'b0;
            z  = (add9[7:0] == 8'h00);
         end
         sm83alu_pkg::OP_SUB, sm83alu_pkg::OP_SBC, sm83alu_pkg::OP_CP: begin
            r8 = sub9[7:0];
            c  = sub9[8];
            h  = subh5[4];
            n  = 1'b1;
            z  = (sub9[7:0] == 8'h00);
            if (item.operation == sm83alu_pkg::OP_CP) begin
               r8 = a;
               wb = 1'b0;
            end
         end
         sm83alu_pkg::OP_AND: begin
            r8 = a & b;
            c  = 1'b0;
            h  = 1'b1;
            n  = 1'b0;
            z  = ((a & b) == 8'h00);
         end
         sm83alu_pkg::OP_XOR: begin
            r8 = a ^ b;
            c  = 1'b0;
            h  = 1'b0;
            n  = 1'b0;
            z  = ((a ^ b) == 8'h00);
         end
         sm83alu_pkg::OP_OR: begin
            r8 = a | b;
            c  = 1'b0;
            h  = 1'b0;
            n  = 1'b0;
            z  = ((a | b) == 8'h00);
         end
         sm83alu_pkg::OP_INC: begin
            r8 = a + 8'h01;
            h  = (a[3:0] == 4'hF);
            n  = 1'b0;
            z  = (a == 8'hFF);
         end
         sm83alu_pkg::OP_DEC: begin
            r8 = a - 8'h01;
            h  = (a[3:0] == 4'h0);
            n  = 1'b1;
            z  = (a == 8'h01);
         end
         sm83alu_pkg::OP_RLC, sm83alu_pkg::OP_RRC, sm83alu_pkg::OP_RL,
         sm83alu_pkg::OP_RR, sm83alu_pkg::OP_SLA, sm83alu_pkg::OP_SRA,
         sm83alu_pkg::OP_SRL, sm83alu_pkg::OP_SWAP: begin
            case (item.operation)
               sm83alu_pkg::OP_RLC: begin r8 = {a[6:0], a[7]};            c = a[7]; end
               sm83alu_pkg::OP_RRC: begin r8 = {a[0], a[7:1]};            c = a[0]; end
               sm83alu_pkg::OP_RL:  begin r8 = {a[6:0], item.carry_in};   c = a[7]; end
               sm83alu_pkg::OP_RR:  begin r8 = {item.carry_in, a[7:1]};   c = a[0]; end
               sm83alu_pkg::OP_SLA: begin r8 = {a[6:0], 1'b0};            c = a[7]; end
               sm83alu_pkg::OP_SRA: begin r8 = {a[7], a[7:1]};            c = a[0]; end
               sm83alu_pkg::OP_SRL: begin r8 = {1'b0, a[7:1]};            c = a[0]; end
               default:             begin r8 = {a[3:0], a[7:4]};          c = 1'b0; end
            endcase
            h = 1'b0;
            n = 1'b0;
            z = (r8 == 8'h00);
         end
         sm83alu_pkg::OP_BIT: begin
            z  = ((a & mask) == 8'h00);
            n  = 1'b0;
            h  = 1'b1;
            wb = 1'b0;
         end
         sm83alu_pkg::OP_RES: begin
            r8 = a & ~mask;
         end
         sm83alu_pkg::OP_SET: begin
            r8 = a | mask;
         end
         sm83alu_pkg::OP_DAA: begin
            r8 = daa_r;
            c  = daa_c;
            h  = 1'b0;
            z  = (daa_r == 8'h00);
         end
         sm83alu_pkg::OP_CPL: begin
            r8 = ~a;
            n  = 1'b1;
            h  = 1'b1;
         end
         sm83alu_pkg::OP_SCF: begin
            c = 1'b1;
            h = 1'b0;
            n = 1'b0;
         end
         sm83alu_pkg::OP_CCF: begin
            c = ~item.carry_in;
            h = 1'b0;
            n = 1'b0;
         end
         sm83alu_pkg::OP_ADD16: begin
            wide = 1'b1;
            r16  = sum17[15:0];
            c    = sum17[16];
            h    = sum13[12];
            n    = 1'b0;
         end
         sm83alu_pkg::OP_ADDSP: begin
            wide = 1'b1;
            r16  = sp16;
            c    = sp9[8];
            h    = sph5[4];
            n    = 1'b0;
            z    = 1'b0;
         end
         default: begin
            // undefined codes leave everything untouched
            wide = 1'b1;
            wb   = 1'b0;
         end
      endcase
   end

   assign result.result_value = wide ? r16 : {8'h00, r8};
   assign result.write_back   = wb;
   assign result.carry_out    = c;
   assign result.half_out     = h;
   assign result.subtract_out = n;
   assign result.zero_out     = z;

endmodule
